// ===== hdl/matrix_inverse_3x3_assert.svh =====
// Assertion macros for the RTL of the 3x3 matrix inverse (matrix_inverse_3x3.sv includes them).
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

`ifndef SYNTHESIS
`define MI3_ASSERT_IMPL(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("matrix inverse assertion failed");
`define MI3_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("matrix inverse assertion failed");
`else
`define MI3_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define MI3_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/mi3_pkg.sv =====
`default_nettype none

package mi3_pkg;

	localparam int ENTRY_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int SHIFT_WIDTH = 6;
	localparam logic [SHIFT_WIDTH-1:0] REL_SHIFT_RESET = SHIFT_WIDTH'(40);

	// Derived widths of the exact integer datapath.
	localparam int PROD_WIDTH = 2 * ENTRY_WIDTH;          // entry times entry
	localparam int COF_WIDTH  = 2 * ENTRY_WIDTH + 1;      // signed cofactor
	localparam int HI_WIDTH   = COF_WIDTH - ENTRY_WIDTH;  // upper part of a cofactor
	localparam int PART_WIDTH = 2 * ENTRY_WIDTH + 1;      // entry times cofactor part
	localparam int DET_WIDTH  = 3 * ENTRY_WIDTH + 1;      // signed determinant
	localparam int ABS_WIDTH  = 3 * ENTRY_WIDTH;          // magnitude of det, max cubed
	localparam int MAG_WIDTH  = 2 * ENTRY_WIDTH;          // magnitude of a cofactor
	localparam int NUM_SHIFT  = 2 * FRAC_BITS + 1;
	localparam int NUM_WIDTH  = ((MAG_WIDTH + NUM_SHIFT) > ABS_WIDTH ?
		(MAG_WIDTH + NUM_SHIFT) : ABS_WIDTH) + 1;
	localparam int DEN_WIDTH  = ABS_WIDTH + 1;
	localparam int CMP_WIDTH  = ((DEN_WIDTH + ENTRY_WIDTH) > NUM_WIDTH ?
		(DEN_WIDTH + ENTRY_WIDTH) : NUM_WIDTH);

	// Cofactor k is a[COF_PA[k]] * a[COF_PB[k]] - a[COF_NA[k]] * a[COF_NB[k]],
	// with the checkerboard sign already folded into the operand order.
	localparam int COF_PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int COF_PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int COF_NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int COF_NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	typedef struct packed {
		logic signed [ENTRY_WIDTH-1:0] in_r0c0;
		logic signed [ENTRY_WIDTH-1:0] in_r0c1;
		logic signed [ENTRY_WIDTH-1:0] in_r0c2;
		logic signed [ENTRY_WIDTH-1:0] in_r1c0;
		logic signed [ENTRY_WIDTH-1:0] in_r1c1;
		logic signed [ENTRY_WIDTH-1:0] in_r1c2;
		logic signed [ENTRY_WIDTH-1:0] in_r2c0;
		logic signed [ENTRY_WIDTH-1:0] in_r2c1;
		logic signed [ENTRY_WIDTH-1:0] in_r2c2;
	} mi3_in_t;

	typedef struct packed {
		logic signed [ENTRY_WIDTH-1:0] out_r0c0;
		logic signed [ENTRY_WIDTH-1:0] out_r0c1;
		logic signed [ENTRY_WIDTH-1:0] out_r0c2;
		logic signed [ENTRY_WIDTH-1:0] out_r1c0;
		logic signed [ENTRY_WIDTH-1:0] out_r1c1;
		logic signed [ENTRY_WIDTH-1:0] out_r1c2;
		logic signed [ENTRY_WIDTH-1:0] out_r2c0;
		logic signed [ENTRY_WIDTH-1:0] out_r2c1;
		logic signed [ENTRY_WIDTH-1:0] out_r2c2;
		logic                          invertible;
		logic                          saturated;
	} mi3_out_t;

endpackage

`default_nettype wire

// ===== hdl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse, signed Q16.16 in and out, by adjugate over determinant.
// Input: an item (nine entries, row by row) is taken at a rising edge where
// start is high and busy is low. busy is always low: the block is a fully
// pipelined datapath and takes one item on every clock cycle.
// Output: each result is shown for exactly one cycle with done high and is
// taken at the edge that ends that cycle. The receiver cannot hold results
// off, and the pipeline never needs it to: nothing ever waits inside.
// Pipeline: each item passes seven stages of exact cofactor, determinant and
// threshold arithmetic, 33 divider stages (one range check, then one quotient
// bit per stage), and the output register.
// Throughput is one item per cycle, set by the nine divider lanes.
// A singular matrix (all zero, or |det| * 2^rel_shift below max|entry|^3)
// returns zeros with invertible low. Otherwise each entry is rounded to
// nearest, ties away from zero, and clipped to range with saturated high.
// Configuration: cfg_we writes rel_shift from cfg_wdata; write it only while
// no item is in flight. Reset sets rel_shift to 40 and empties the pipeline.
`default_nettype none

module matrix_inverse_3x3
	import mi3_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  mi3_in_t                 item_in,
	output logic                    done,
	output mi3_out_t                result,
	input  wire                     cfg_we,
	input  wire  [SHIFT_WIDTH-1:0]  cfg_wdata
);

	`include "matrix_inverse_3x3_assert.svh"

	localparam int LATENCY = ENTRY_WIDTH + 9;

	function automatic logic [ENTRY_WIDTH-1:0] max3(
		input logic [ENTRY_WIDTH-1:0] x,
		input logic [ENTRY_WIDTH-1:0] y,
		input logic [ENTRY_WIDTH-1:0] z
	);
		logic [ENTRY_WIDTH-1:0] m;
		m = (x > y) ? x : y;
		return (m > z) ? m : z;
	endfunction

	logic [SHIFT_WIDTH-1:0] rel_shift_q;
	logic                   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_shift_q <= REL_SHIFT_RESET;
		end else if (cfg_we) begin
			rel_shift_q <= cfg_wdata;
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// The entries as an array, row by row.
	logic signed [ENTRY_WIDTH-1:0] a [9];
	assign a[0] = item_in.in_r0c0;
	assign a[1] = item_in.in_r0c1;
	assign a[2] = item_in.in_r0c2;
	assign a[3] = item_in.in_r1c0;
	assign a[4] = item_in.in_r1c1;
	assign a[5] = item_in.in_r1c2;
	assign a[6] = item_in.in_r2c0;
	assign a[7] = item_in.in_r2c1;
	assign a[8] = item_in.in_r2c2;

	// Valid bits of the arithmetic stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1: the eighteen entry products and the entry magnitudes.
	logic signed [PROD_WIDTH-1:0]  pp_s1 [9];
	logic signed [PROD_WIDTH-1:0]  pn_s1 [9];
	logic        [ENTRY_WIDTH-1:0] mag_s1 [9];
	logic signed [ENTRY_WIDTH-1:0] a_s1 [3];

	for (genvar k = 0; k < 9; k++) begin : g_s1
		always_ff @(posedge clk) begin
			pp_s1[k]  <= PROD_WIDTH'(a[COF_PA[k]]) * PROD_WIDTH'(a[COF_PB[k]]);
			pn_s1[k]  <= PROD_WIDTH'(a[COF_NA[k]]) * PROD_WIDTH'(a[COF_NB[k]]);
			mag_s1[k] <= a[k][ENTRY_WIDTH-1] ? ENTRY_WIDTH'(-a[k]) : ENTRY_WIDTH'(a[k]);
		end
	end

	always_ff @(posedge clk) begin
		a_s1[0] <= a[0];
		a_s1[1] <= a[1];
		a_s1[2] <= a[2];
	end

	// Stage 2: cofactors and the maximum magnitude of each row.
	logic signed [COF_WIDTH-1:0]   cof_s2 [9];
	logic        [ENTRY_WIDTH-1:0] gmax_s2 [3];
	logic signed [ENTRY_WIDTH-1:0] a_s2 [3];

	for (genvar k = 0; k < 9; k++) begin : g_s2
		always_ff @(posedge clk) begin
			cof_s2[k] <= COF_WIDTH'(pp_s1[k]) - COF_WIDTH'(pn_s1[k]);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_s2_max
		always_ff @(posedge clk) begin
			gmax_s2[g] <= max3(mag_s1[3*g], mag_s1[3*g+1], mag_s1[3*g+2]);
			a_s2[g]    <= a_s1[g];
		end
	end

	// Stage 3: first row times its cofactors, each cofactor split in a low and
	// a high part so that each multiplier stays near entry width.
	logic signed [PART_WIDTH-1:0]  plo_s3 [3];
	logic signed [PART_WIDTH-1:0]  phi_s3 [3];
	logic        [ENTRY_WIDTH-1:0] amax_s3;
	logic signed [COF_WIDTH-1:0]   cof_s3 [9];

	for (genvar j = 0; j < 3; j++) begin : g_s3
		logic [ENTRY_WIDTH-1:0] lo;
		logic [HI_WIDTH-1:0]    hi;

		assign lo = cof_s2[3*j][ENTRY_WIDTH-1:0];
		assign hi = cof_s2[3*j][COF_WIDTH-1:ENTRY_WIDTH];

		always_ff @(posedge clk) begin
			plo_s3[j] <= PART_WIDTH'(a_s2[j]) * PART_WIDTH'($signed({1'b0, lo}));
			phi_s3[j] <= PART_WIDTH'(a_s2[j]) * PART_WIDTH'($signed(hi));
		end
	end

	always_ff @(posedge clk) begin
		amax_s3 <= max3(gmax_s2[0], gmax_s2[1], gmax_s2[2]);
		cof_s3  <= cof_s2;
	end

	// Stage 4: determinant terms and the square of the largest magnitude.
	logic signed [DET_WIDTH-1:0]   term_s4 [3];
	logic        [PROD_WIDTH-1:0]  sq_s4;
	logic        [ENTRY_WIDTH-1:0] amax_s4;
	logic signed [COF_WIDTH-1:0]   cof_s4 [9];

	for (genvar j = 0; j < 3; j++) begin : g_s4
		always_ff @(posedge clk) begin
			term_s4[j] <= (DET_WIDTH'(phi_s3[j]) <<< ENTRY_WIDTH) + DET_WIDTH'(plo_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		sq_s4   <= PROD_WIDTH'(amax_s3) * PROD_WIDTH'(amax_s3);
		amax_s4 <= amax_s3;
		cof_s4  <= cof_s3;
	end

	// Stage 5: determinant, and the cube in two partial products.
	logic signed [DET_WIDTH-1:0]  det_s5;
	logic        [PROD_WIDTH-1:0] clo_s5;
	logic        [PROD_WIDTH-1:0] chi_s5;
	logic                         zero_s5;
	logic signed [COF_WIDTH-1:0]  cof_s5 [9];

	always_ff @(posedge clk) begin
		det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
		clo_s5  <= PROD_WIDTH'(sq_s4[ENTRY_WIDTH-1:0]) * PROD_WIDTH'(amax_s4);
		chi_s5  <= PROD_WIDTH'(sq_s4[PROD_WIDTH-1:ENTRY_WIDTH]) * PROD_WIDTH'(amax_s4);
		zero_s5 <= (amax_s4 == '0);
		cof_s5  <= cof_s4;
	end

	// Stage 6: magnitudes and signs; the cube less one for the threshold.
	logic [ABS_WIDTH-1:0] absdet_s6;
	logic                 dneg_s6;
	logic [ABS_WIDTH-1:0] rhsm1_s6;
	logic                 zero_s6;
	logic [MAG_WIDTH-1:0] cmag_s6 [9];
	logic                 cneg_s6 [9];

	always_ff @(posedge clk) begin
		absdet_s6 <= det_s5[DET_WIDTH-1] ? ABS_WIDTH'(-det_s5) : ABS_WIDTH'(det_s5);
		dneg_s6   <= det_s5[DET_WIDTH-1];
		rhsm1_s6  <= (ABS_WIDTH'(chi_s5) << ENTRY_WIDTH) + ABS_WIDTH'(clo_s5)
			- ABS_WIDTH'(1);
		zero_s6   <= zero_s5;
	end

	for (genvar k = 0; k < 9; k++) begin : g_s6
		always_ff @(posedge clk) begin
			cmag_s6[k] <= cof_s5[k][COF_WIDTH-1] ? MAG_WIDTH'(-cof_s5[k])
				: MAG_WIDTH'(cof_s5[k]);
			cneg_s6[k] <= cof_s5[k][COF_WIDTH-1];
		end
	end

	// Stage 7: singularity threshold and the divider operands. The rounded
	// quotient is floor((2 * |cof| * 2^(2F) + |det|) / (2 * |det|)).
	// |det| * 2^s < cube holds exactly when |det| <= (cube - 1) >> s.
	logic [ABS_WIDTH-1:0] thr_s7;
	logic [ABS_WIDTH-1:0] absdet_s7;
	logic                 zero_s7;
	logic [NUM_WIDTH-1:0] num_s7 [9];
	logic [DEN_WIDTH-1:0] den_s7;
	logic                 neg_s7 [9];

	always_ff @(posedge clk) begin
		thr_s7    <= rhsm1_s6 >> rel_shift_q;
		absdet_s7 <= absdet_s6;
		zero_s7   <= zero_s6;
		den_s7    <= DEN_WIDTH'(absdet_s6) << 1;
	end

	for (genvar k = 0; k < 9; k++) begin : g_s7
		always_ff @(posedge clk) begin
			num_s7[k] <= (NUM_WIDTH'(cmag_s6[k]) << NUM_SHIFT) + NUM_WIDTH'(absdet_s6);
			neg_s7[k] <= cneg_s6[k] ^ dneg_s6;
		end
	end

	// Divider lanes, one per inverse entry, with the valid and singular flags
	// travelling alongside.
	logic [ENTRY_WIDTH-1:0] quo_l [9];
	logic                   ov_l  [9];
	logic                   neg_l [9];
	logic                   vld_dv_s  [ENTRY_WIDTH+1];
	logic                   sing_dv_s [ENTRY_WIDTH+1];

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div u_div (
			.clk    (clk),
			.num    (num_s7[k]),
			.den    (den_s7),
			.neg_in (neg_s7[k]),
			.quo    (quo_l[k]),
			.ov     (ov_l[k]),
			.neg    (neg_l[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv_s[0] <= 1'b0;
		end else begin
			vld_dv_s[0] <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		sing_dv_s[0] <= zero_s7 || (absdet_s7 <= thr_s7);
	end

	for (genvar i = 1; i <= ENTRY_WIDTH; i++) begin : g_flags
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[i] <= 1'b0;
			end else begin
				vld_dv_s[i] <= vld_dv_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			sing_dv_s[i] <= sing_dv_s[i-1];
		end
	end

	// Output stage: sign, clipping and the singular case.
	logic signed [ENTRY_WIDTH-1:0] val_l [9];
	logic        [8:0]             sat_l;
	logic                          sing_out;

	assign sing_out = sing_dv_s[ENTRY_WIDTH];

	for (genvar k = 0; k < 9; k++) begin : g_out
		logic sat_pos;
		logic sat_neg;

		assign sat_pos = ov_l[k] || quo_l[k][ENTRY_WIDTH-1];
		assign sat_neg = ov_l[k] || (quo_l[k][ENTRY_WIDTH-1] && |quo_l[k][ENTRY_WIDTH-2:0]);

		always_comb begin
			if (sing_out) begin
				val_l[k] = '0;
				sat_l[k] = 1'b0;
			end else if (neg_l[k]) begin
				val_l[k] = sat_neg ? {1'b1, {(ENTRY_WIDTH-1){1'b0}}} : -$signed(quo_l[k]);
				sat_l[k] = sat_neg;
			end else begin
				val_l[k] = sat_pos ? {1'b0, {(ENTRY_WIDTH-1){1'b1}}} : $signed(quo_l[k]);
				sat_l[k] = sat_pos;
			end
		end
	end

	logic     done_q;
	mi3_out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_dv_s[ENTRY_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_r0c0   <= val_l[0];
		result_q.out_r0c1   <= val_l[1];
		result_q.out_r0c2   <= val_l[2];
		result_q.out_r1c0   <= val_l[3];
		result_q.out_r1c1   <= val_l[4];
		result_q.out_r1c2   <= val_l[5];
		result_q.out_r2c0   <= val_l[6];
		result_q.out_r2c1   <= val_l[7];
		result_q.out_r2c2   <= val_l[8];
		result_q.invertible <= !sing_out;
		result_q.saturated  <= |sat_l;
	end

	assign done   = done_q;
	assign result = result_q;

	// A result only appears for an item accepted a fixed time earlier.
	`MI3_ASSERT_IMPL(a_done_latency, clk, arst_n, done, $past(start && !busy, LATENCY))
	// Clipping is only ever reported together with a valid inverse.
	`MI3_ASSERT_IMPL(a_sat_needs_inv, clk, arst_n, done && result.saturated, result.invertible)
	// A singular verdict at the divider end yields a zero, unclipped result.
	`MI3_ASSERT_NEXT(a_sing_result, clk, arst_n, vld_dv_s[ENTRY_WIDTH] && sing_out, !result.invertible && !result.saturated && result.out_r0c0 == '0 && result.out_r2c2 == '0)

endmodule

`default_nettype wire

// ===== hdl/mi3_div.sv =====
`default_nettype none

// One lane of the pipelined restoring divider. The first stage checks whether
// the quotient reaches 2^ENTRY_WIDTH, each later stage settles one quotient bit,
// most significant first.
module mi3_div
	import mi3_pkg::*;
(
	input  wire                          clk,
	input  wire  [NUM_WIDTH-1:0]         num,
	input  wire  [DEN_WIDTH-1:0]         den,
	input  wire                          neg_in,
	output logic [ENTRY_WIDTH-1:0]       quo,
	output logic                         ov,
	output logic                         neg
);

	logic [NUM_WIDTH-1:0]   rem_s [ENTRY_WIDTH+1];
	logic [DEN_WIDTH-1:0]   den_s [ENTRY_WIDTH+1];
	logic [ENTRY_WIDTH-1:0] quo_s [ENTRY_WIDTH+1];
	logic                   ov_s  [ENTRY_WIDTH+1];
	logic                   neg_s [ENTRY_WIDTH+1];

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ov_s[0]  <= CMP_WIDTH'(num) >= (CMP_WIDTH'(den) << ENTRY_WIDTH);
		neg_s[0] <= neg_in;
	end

	for (genvar i = 1; i <= ENTRY_WIDTH; i++) begin : g_step
		localparam int K = ENTRY_WIDTH - i;
		logic [CMP_WIDTH-1:0] rem_x;
		logic [CMP_WIDTH-1:0] den_x;
		logic                 ge;

		assign rem_x = CMP_WIDTH'(rem_s[i-1]);
		assign den_x = CMP_WIDTH'(den_s[i-1]) << K;
		assign ge    = rem_x >= den_x;

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? NUM_WIDTH'(rem_x - den_x) : rem_s[i-1];
			den_s[i] <= den_s[i-1];
			quo_s[i] <= quo_s[i-1] | (ENTRY_WIDTH'(ge) << K);
			ov_s[i]  <= ov_s[i-1];
			neg_s[i] <= neg_s[i-1];
		end
	end

	assign quo = quo_s[ENTRY_WIDTH];
	assign ov  = ov_s[ENTRY_WIDTH];
	assign neg = neg_s[ENTRY_WIDTH];

endmodule

`default_nettype wire

// ===== test/mi3_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mi3_checker
	import mi3_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire                    busy,
	input  mi3_in_t                item_in,
	input  wire                    done,
	input  mi3_out_t               result,
	input  wire                    cfg_we,
	input  wire  [SHIFT_WIDTH-1:0] cfg_wdata,
	output int                     fails,
	output int                     pending
);

	typedef logic signed [255:0] wide_t;
	typedef logic [ENTRY_WIDTH-1:0] entry_t;

	mi3_out_t               inverse_q [$];
	logic [SHIFT_WIDTH-1:0] rel_shift;

	function automatic wide_t wabs(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	// Exact adjugate over determinant, with the relative singularity test.
	function automatic mi3_out_t invert_predict(input mi3_in_t m,
		input logic [SHIFT_WIDTH-1:0] sh);
		wide_t    a [9];
		wide_t    cof [9];
		wide_t    det, amax, absdet, lhs, rhs, num, q, lim;
		entry_t   e [9];
		logic     neg, sat;
		mi3_out_t r;
		a[0] = wide_t'(m.in_r0c0); a[1] = wide_t'(m.in_r0c1); a[2] = wide_t'(m.in_r0c2);
		a[3] = wide_t'(m.in_r1c0); a[4] = wide_t'(m.in_r1c1); a[5] = wide_t'(m.in_r1c2);
		a[6] = wide_t'(m.in_r2c0); a[7] = wide_t'(m.in_r2c1); a[8] = wide_t'(m.in_r2c2);
		cof[0] = a[4] * a[8] - a[5] * a[7];
		cof[1] = a[2] * a[7] - a[1] * a[8];
		cof[2] = a[1] * a[5] - a[2] * a[4];
		cof[3] = a[5] * a[6] - a[3] * a[8];
		cof[4] = a[0] * a[8] - a[2] * a[6];
		cof[5] = a[2] * a[3] - a[0] * a[5];
		cof[6] = a[3] * a[7] - a[4] * a[6];
		cof[7] = a[1] * a[6] - a[0] * a[7];
		cof[8] = a[0] * a[4] - a[1] * a[3];
		det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
		amax = '0;
		for (int i = 0; i < 9; i++)
			if (wabs(a[i]) > amax) amax = wabs(a[i]);
		absdet = wabs(det);
		lhs = absdet <<< sh;
		rhs = amax * amax * amax;
		r = '0;
		if (amax == 0 || lhs < rhs) return r;
		sat = 1'b0;
		for (int i = 0; i < 9; i++) begin
			neg = (cof[i] < 0) != (det < 0);
			num = wabs(cof[i]) <<< (2 * FRAC_BITS);
			// Adding half the divisor before dividing rounds ties away from zero.
			q = ((num <<< 1) + absdet) / (absdet <<< 1);
			lim = wide_t'(1) <<< (ENTRY_WIDTH - 1);
			if (!neg) lim = lim - 1;
			if (q > lim) begin
				q = lim;
				sat = 1'b1;
			end
			if (neg) q = -q;
			e[i] = q[ENTRY_WIDTH-1:0];
		end
		r.out_r0c0 = e[0]; r.out_r0c1 = e[1]; r.out_r0c2 = e[2];
		r.out_r1c0 = e[3]; r.out_r1c1 = e[4]; r.out_r1c2 = e[5];
		r.out_r2c0 = e[6]; r.out_r2c1 = e[7]; r.out_r2c2 = e[8];
		r.invertible = 1'b1;
		r.saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mi3_out_t want;
		if (!arst_n) begin
			rel_shift <= REL_SHIFT_RESET;
			inverse_q.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (inverse_q.size() == 0) begin
					if (fails < 10)
						$display("%0t: result with no item outstanding: %h", $realtime, result);
					fails <= fails + 1;
				end else begin
					want = inverse_q.pop_front();
					// The packed struct is compared as a whole; while under ten fails are counted, a mismatch prints every field.
					if (result !== want) begin
						if (fails < 10) begin
							$display("%0t: inverse mismatch", $realtime);
							$display("  expected %h %h %h / %h %h %h / %h %h %h inv=%b sat=%b",
								want.out_r0c0, want.out_r0c1, want.out_r0c2,
								want.out_r1c0, want.out_r1c1, want.out_r1c2,
								want.out_r2c0, want.out_r2c1, want.out_r2c2,
								want.invertible, want.saturated);
							$display("  actual   %h %h %h / %h %h %h / %h %h %h inv=%b sat=%b",
								result.out_r0c0, result.out_r0c1, result.out_r0c2,
								result.out_r1c0, result.out_r1c1, result.out_r1c2,
								result.out_r2c0, result.out_r2c1, result.out_r2c2,
								result.invertible, result.saturated);
						end
						fails <= fails + 1;
					end
				end
			end
			if (start && !busy)
				inverse_q.push_back(invert_predict(item_in, rel_shift));
			if (cfg_we)
				rel_shift <= cfg_wdata;
			pending <= inverse_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== test/matrix_inverse_3x3_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3_tb;
	import mi3_pkg::*;

	typedef logic [ENTRY_WIDTH-1:0] entry_t;

	localparam entry_t ONE    = entry_t'(1 << FRAC_BITS);
	localparam entry_t MAXPOS = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};
	localparam entry_t MAXNEG = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	mi3_in_t                item_in;
	logic                   done;
	mi3_out_t               result;
	logic                   cfg_we;
	logic [SHIFT_WIDTH-1:0] cfg_wdata;
	int                     fails;
	int                     pending;

	// Percent chance that the sender sits out a given cycle.
	int                     idle_pct;

	matrix_inverse_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item_in   (item_in),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// The checker sits beside the block, predicts every inverse and counts mismatches.
	mi3_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item_in   (item_in),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Builds an item from nine raw entries, row by row.
	function automatic mi3_in_t make_matrix(input entry_t e [9]);
		mi3_in_t m;
		m.in_r0c0 = e[0]; m.in_r0c1 = e[1]; m.in_r0c2 = e[2];
		m.in_r1c0 = e[3]; m.in_r1c1 = e[4]; m.in_r1c2 = e[5];
		m.in_r2c0 = e[6]; m.in_r2c1 = e[7]; m.in_r2c2 = e[8];
		return m;
	endfunction

	// A small entry within about plus or minus three, where inverses stay meaningful.
	function automatic entry_t small_entry();
		return entry_t'(int'($urandom_range(0, 32'h60000)) - 32'h30000);
	endfunction

	function automatic entry_t extreme_entry();
		case ($urandom_range(0, 5))
			0: return MAXPOS;
			1: return MAXNEG;
			2: return '0;
			3: return entry_t'(1);
			4: return '1;
			default: return ONE;
		endcase
	endfunction

	// A large share of random matrices have small entries, so that the divider and
	// rounding see real work; the rest are singular, extreme, full range, tiny diagonal or mixed.
	function automatic mi3_in_t random_matrix();
		entry_t e [9];
		int     kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			case (kind)
				0, 1, 2, 3: e[i] = small_entry();
				4, 5:       e[i] = entry_t'($urandom);
				7:          e[i] = extreme_entry();
				8:          e[i] = (i % 4 == 0) ? entry_t'($urandom_range(1, 255)) : '0;
				default: begin
					case ($urandom_range(0, 2))
						0: e[i] = small_entry();
						1: e[i] = entry_t'($urandom);
						default: e[i] = extreme_entry();
					endcase
				end
			endcase
		end
		// Third row is the sum of the first two, so the determinant is exactly zero.
		if (kind == 6) begin
			for (int i = 0; i < 6; i++) e[i] = small_entry();
			for (int i = 0; i < 3; i++) e[6 + i] = e[i] + e[3 + i];
		end
		return make_matrix(e);
	endfunction

	// Offers one item, sitting out random cycles first, and returns once it is taken.
	task automatic send_matrix(input mi3_in_t m);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < idle_pct) begin
				start = 1'b0;
				item_in = mi3_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
			end else begin
				start = 1'b1;
				item_in = m;
				@(posedge clk);
				if (!busy) break;
			end
		end
	endtask

	// The block keeps no state across items besides the register, so once every result is in
	// the pipeline is empty and the register may be rewritten.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_shift(input logic [SHIFT_WIDTH-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = SHIFT_WIDTH'($urandom);
	endtask

	task automatic directed_matrices();
		entry_t e [9];
		// All zero: the largest entry is zero, so the item is singular.
		foreach (e[i]) e[i] = '0;
		send_matrix(make_matrix(e));
		// Identity and scaled identities.
		foreach (e[i]) e[i] = (i % 4 == 0) ? ONE : '0;
		send_matrix(make_matrix(e));
		foreach (e[i]) e[i] = (i % 4 == 0) ? -ONE : '0;
		send_matrix(make_matrix(e));
		foreach (e[i]) e[i] = (i % 4 == 0) ? entry_t'(3 * ONE) : '0;
		send_matrix(make_matrix(e));
		// Tiny diagonal: the inverse is far out of range and saturates.
		foreach (e[i]) e[i] = (i % 4 == 0) ? entry_t'(1) : '0;
		send_matrix(make_matrix(e));
		foreach (e[i]) e[i] = (i % 4 == 0) ? '1 : '0;
		send_matrix(make_matrix(e));
		// Most negative entries on the diagonal, magnitude used exactly.
		foreach (e[i]) e[i] = (i % 4 == 0) ? MAXNEG : '0;
		send_matrix(make_matrix(e));
		foreach (e[i]) e[i] = (i % 4 == 0) ? MAXPOS : '0;
		send_matrix(make_matrix(e));
		// Every entry at one extreme: rank one, singular.
		foreach (e[i]) e[i] = MAXPOS;
		send_matrix(make_matrix(e));
		foreach (e[i]) e[i] = MAXNEG;
		send_matrix(make_matrix(e));
		// Checkerboard of the two extremes.
		foreach (e[i]) e[i] = (i % 2 == 0) ? MAXPOS : MAXNEG;
		send_matrix(make_matrix(e));
		// Nearly singular: one tiny perturbation of a rank-two matrix.
		e = '{ONE, ONE, '0, ONE, ONE + 1, '0, '0, '0, ONE};
		send_matrix(make_matrix(e));
		// Entries two and three make halfway quotients likely.
		e = '{entry_t'(2 * ONE), ONE, '0, ONE, entry_t'(2 * ONE), ONE, '0, ONE,
			entry_t'(2 * ONE)};
		send_matrix(make_matrix(e));
		e = '{entry_t'(3), entry_t'(1), '0, '0, entry_t'(2), '0, '0, '0, ONE};
		send_matrix(make_matrix(e));
		for (int i = 0; i < 6; i++) send_matrix(random_matrix());
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) send_matrix(random_matrix());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item_in = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items run at the reset threshold.
		directed_matrices();
		drain();

		// Each phase picks a threshold and an idle rate; the drain before each
		// write also makes the sender wait until every result is back.
		write_shift(SHIFT_WIDTH'(0));
		idle_pct = 0;
		random_phase(200);
		drain();

		write_shift('1);
		idle_pct = 70;
		random_phase(200);
		drain();

		write_shift(SHIFT_WIDTH'(40));
		idle_pct = 12;
		random_phase(200);
		drain();

		write_shift(SHIFT_WIDTH'($urandom_range(1, 62)));
		idle_pct = 70;
		random_phase(200);
		drain();

		write_shift(SHIFT_WIDTH'($urandom_range(20, 60)));
		idle_pct = 0;
		random_phase(200);
		drain();

		// Allow a margin past the last result.
		repeat (60) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("matrix_inverse_3x3_tb: PASS");
		end else begin
			$display("matrix_inverse_3x3_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("matrix_inverse_3x3_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
